@@ rtl/mp2d_pkg.sv @@
// Package with shared types, widths and codes of the int8 2-D max pooling block.
`timescale 1ns / 1ps
package mp2d_pkg;

  localparam int MAX_ELEMS_DEF  = 4096;
  localparam int MAX_FILTER_DEF = 8;

  localparam int ADDR_W     = 12;
  localparam int ROW_W      = 8;
  localparam int COL_W      = 8;
  localparam int CH_W       = 6;
  localparam int DIM_W      = 9;
  localparam int NCH_W      = 7;
  localparam int FCFG_W     = 4;
  localparam int PAD_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Window coordinate before range check, two's complement.
  localparam int COORD_W = 14;
  // Pixel index r*in_width + c, and flat element index.
  localparam int PIX_W = 19;
  localparam int TAP_W = 27;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT     = 3'd0,
    REG_IN_WIDTH      = 3'd1,
    REG_CHANNELS      = 3'd2,
    REG_POOL_ROWS     = 3'd3,
    REG_POOL_COLS     = 3'd4,
    REG_STRIDE_Y      = 3'd5,
    REG_STRIDE_X      = 3'd6,
    REG_PAD_TOP_LEFT  = 3'd7
  } cfg_reg_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic signed [7:0] MIN_VALUE = -8'sd128;

  typedef struct packed {
    logic              load_query;
    logic              mem_write;
    logic              setup;
    logic              issue;
    logic [FCFG_W-1:0] fy;
    logic [FCFG_W-1:0] fx;
    logic              load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              empty;
    logic [FCFG_W-1:0] fh;
    logic [FCFG_W-1:0] fw;
  } dp_status_t;

endpackage

@@ rtl/mp2d_ifs.sv @@
// Valid/ready channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps
interface mp2d_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [mp2d_pkg::ADDR_W-1:0]         elem_addr;
  logic signed [7:0]                   elem_value;
  logic [mp2d_pkg::ROW_W-1:0]          out_row;
  logic [mp2d_pkg::COL_W-1:0]          out_col;
  logic [mp2d_pkg::CH_W-1:0]           channel;

  modport source (output valid, req_type, elem_addr, elem_value, out_row, out_col, channel,
                  input ready);
  modport sink (input valid, req_type, elem_addr, elem_value, out_row, out_col, channel,
                output ready);
endinterface

interface mp2d_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] pooled_max;
  logic              window_had_data;

  modport source (output valid, pooled_max, window_had_data, input ready);
  modport sink (input valid, pooled_max, window_had_data, output ready);
endinterface

interface mp2d_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mp2d_pkg::CFG_IDX_W-1:0]      index;
  logic [mp2d_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/int8_max_pool_2d.sv @@
// Top level of the int8 2-D max pooling block: controller plus datapath.
// Write transaction: accepted while idle, ready again in the next cycle.
// Query transaction: the result follows the setup step, the tap walk and the pipeline drain;
// an empty window skips the walk and drain. The tap walk issues one memory read per cycle.
// A finished result waits in the output register while later writes are taken.
// Synchronous active-high reset restores register defaults; the tensor store is not cleared.
`timescale 1ns / 1ps
module int8_max_pool_2d #(
  parameter int MAX_ELEMS  = mp2d_pkg::MAX_ELEMS_DEF,
  parameter int MAX_FILTER = mp2d_pkg::MAX_FILTER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mp2d_in_if.sink     req,
  mp2d_out_if.source  rsp,
  mp2d_cfg_if.sink    cfg
);

  mp2d_pkg::ctrl_cmd_t  cmd;
  mp2d_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;

  assign cfg.ready = 1'b1;
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  mp2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .req_type  (req.req_type),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mp2d_datapath #(
    .MAX_ELEMS  (MAX_ELEMS),
    .MAX_FILTER (MAX_FILTER)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .elem_addr       (req.elem_addr),
    .elem_value      (req.elem_value),
    .out_row         (req.out_row),
    .out_col         (req.out_col),
    .channel         (req.channel),
    .cmd             (cmd),
    .status          (status),
    .pooled_max      (rsp.pooled_max),
    .window_had_data (rsp.window_had_data)
  );

endmodule

@@ rtl/mp2d_datapath.sv @@
// Datapath: configuration registers, tensor memory, tap address pipeline and running maximum.
`timescale 1ns / 1ps
module mp2d_datapath #(
  parameter int MAX_ELEMS  = mp2d_pkg::MAX_ELEMS_DEF,
  parameter int MAX_FILTER = mp2d_pkg::MAX_FILTER_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mp2d_pkg::ADDR_W-1:0]         elem_addr,
  input  logic signed [7:0]                   elem_value,
  input  logic [mp2d_pkg::ROW_W-1:0]          out_row,
  input  logic [mp2d_pkg::COL_W-1:0]          out_col,
  input  logic [mp2d_pkg::CH_W-1:0]           channel,
  input  mp2d_pkg::ctrl_cmd_t                 cmd,
  output mp2d_pkg::dp_status_t                status,
  output logic signed [7:0]                   pooled_max,
  output logic                                window_had_data
);

  localparam int AW  = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW  = mp2d_pkg::COORD_W;
  localparam int FW  = mp2d_pkg::FCFG_W;

  logic [mp2d_pkg::DIM_W-1:0]  in_height;
  logic [mp2d_pkg::DIM_W-1:0]  in_width;
  logic [mp2d_pkg::NCH_W-1:0]  channels;
  logic [FW-1:0]               pool_rows;
  logic [FW-1:0]               pool_cols;
  logic [FW-1:0]               stride_y;
  logic [FW-1:0]               stride_x;
  logic [mp2d_pkg::PAD_W-1:0]  pad_top_left;

  logic [mp2d_pkg::ROW_W-1:0]  q_row;
  logic [mp2d_pkg::COL_W-1:0]  q_col;
  logic [mp2d_pkg::CH_W-1:0]   q_ch;

  logic [CW-1:0]               row_base;
  logic [CW-1:0]               col_base;
  logic [CW-1:0]               row_base_next;
  logic [CW-1:0]               col_base_next;
  logic [CW-1:0]               tap_r;
  logic [CW-1:0]               tap_c;
  logic                        tap_in;

  logic                        s1_valid;
  logic [mp2d_pkg::DIM_W-1:0]  s1_r;
  logic [mp2d_pkg::DIM_W-1:0]  s1_c;
  logic                        s2_valid;
  logic [mp2d_pkg::PIX_W-1:0]  s2_pix;
  logic                        s3_valid;
  logic [mp2d_pkg::TAP_W-1:0]  s3_addr;
  logic                        s4_valid;
  logic signed [7:0]           rd_data;

  logic signed [7:0]           best;
  logic                        any_tap;

  logic [7:0]                  mem [MAX_ELEMS];

  // Window sizes above the supported maximum saturate.
  assign status.fh = (32'(pool_rows) > MAX_FILTER) ? FW'(MAX_FILTER) : pool_rows;
  assign status.fw = (32'(pool_cols) > MAX_FILTER) ? FW'(MAX_FILTER) : pool_cols;
  assign status.empty = (mp2d_pkg::NCH_W'(q_ch) >= channels) ||
                        (status.fh == '0) || (status.fw == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height     <= mp2d_pkg::DIM_W'(1);
      in_width      <= mp2d_pkg::DIM_W'(1);
      channels      <= mp2d_pkg::NCH_W'(1);
      pool_rows     <= FW'(2);
      pool_cols     <= FW'(2);
      stride_y      <= FW'(2);
      stride_x      <= FW'(2);
      pad_top_left  <= '0;
    end else if (cfg_write) begin
      case (mp2d_pkg::cfg_reg_t'(cfg_index))
        mp2d_pkg::REG_IN_HEIGHT:     in_height     <= cfg_data;
        mp2d_pkg::REG_IN_WIDTH:      in_width      <= cfg_data;
        mp2d_pkg::REG_CHANNELS:      channels      <= cfg_data[mp2d_pkg::NCH_W-1:0];
        mp2d_pkg::REG_POOL_ROWS:     pool_rows     <= cfg_data[FW-1:0];
        mp2d_pkg::REG_POOL_COLS:     pool_cols     <= cfg_data[FW-1:0];
        mp2d_pkg::REG_STRIDE_Y:      stride_y      <= cfg_data[FW-1:0];
        mp2d_pkg::REG_STRIDE_X:      stride_x      <= cfg_data[FW-1:0];
        mp2d_pkg::REG_PAD_TOP_LEFT:  pad_top_left  <= cfg_data[mp2d_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_row <= out_row;
      q_col <= out_col;
      q_ch  <= channel;
    end
  end

  // Window origin; it may be negative because of padding.
  assign row_base_next = CW'(q_row) * CW'(stride_y) - CW'(pad_top_left[5:3]);
  assign col_base_next = CW'(q_col) * CW'(stride_x) - CW'(pad_top_left[2:0]);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      row_base <= row_base_next;
      col_base <= col_base_next;
    end
  end

  assign tap_r  = row_base + CW'(cmd.fy);
  assign tap_c  = col_base + CW'(cmd.fx);
  assign tap_in = !tap_r[CW-1] && (tap_r < CW'(in_height)) &&
                  !tap_c[CW-1] && (tap_c < CW'(in_width));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue && tap_in;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid && (32'(s3_addr) < MAX_ELEMS);
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= tap_r[mp2d_pkg::DIM_W-1:0];
    s1_c    <= tap_c[mp2d_pkg::DIM_W-1:0];
    s2_pix  <= mp2d_pkg::PIX_W'(s1_r) * mp2d_pkg::PIX_W'(in_width) +
               mp2d_pkg::PIX_W'(s1_c);
    s3_addr <= mp2d_pkg::TAP_W'(s2_pix) * mp2d_pkg::TAP_W'(channels) +
               mp2d_pkg::TAP_W'(q_ch);
  end

  // Tensor store with separate write and read ports: writes happen only between queries.
  always_ff @(posedge clk) begin
    if (cmd.mem_write && (32'(elem_addr) < MAX_ELEMS)) begin
      mem[AW'(elem_addr)] <= elem_value;
    end
    rd_data <= $signed(mem[AW'(s3_addr)]);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      best    <= mp2d_pkg::MIN_VALUE;
      any_tap <= 1'b0;
    end else if (s4_valid) begin
      if (rd_data > best) begin
        best <= rd_data;
      end
      any_tap <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pooled_max      <= best;
      window_had_data <= any_tap;
    end
  end

endmodule

@@ rtl/mp2d_ctrl.sv @@
// Controller: request sequencing, window tap walk, pipeline drain and result handshake.
`timescale 1ns / 1ps
module mp2d_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mp2d_pkg::dp_status_t status,
  output mp2d_pkg::ctrl_cmd_t  cmd
);

  // Drain cycles between the last tap issue and the load of the finished maximum.
  localparam int DRAIN_CYCLES = 4;
  localparam int DW = $clog2(DRAIN_CYCLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                      state;
  logic [mp2d_pkg::FCFG_W-1:0] fy;
  logic [mp2d_pkg::FCFG_W-1:0] fx;
  logic [DW-1:0]               drain_cnt;
  logic                        accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign cmd.load_query = accept && (req_type == mp2d_pkg::REQ_QUERY);
  assign cmd.mem_write  = accept && (req_type == mp2d_pkg::REQ_WRITE);
  assign cmd.setup      = (state == ST_SETUP);
  assign cmd.issue      = (state == ST_RUN);
  assign cmd.fy         = fy;
  assign cmd.fx         = fx;
  assign cmd.load_out   = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fy        <= '0;
      fx        <= '0;
      drain_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.load_query) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          fy <= '0;
          fx <= '0;
          state <= status.empty ? ST_FINISH : ST_RUN;
        end
        ST_RUN: begin
          if (fx == status.fw - 1'b1) begin
            fx <= '0;
            if (fy == status.fh - 1'b1) begin
              drain_cnt <= '0;
              state     <= ST_DRAIN;
            end else begin
              fy <= fy + 1'b1;
            end
          end else begin
            fx <= fx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt == DW'(DRAIN_CYCLES - 1)) begin
            state <= ST_FINISH;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/mp2d_checker.sv @@
// Port-level checker for the int8 2-D max pooling block, bound to the top level.
`timescale 1ns / 1ps
module mp2d_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] pooled_max,
  input logic              window_had_data
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction completed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // An empty window reports the minimum value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_had_data |-> pooled_max == mp2d_pkg::MIN_VALUE)
    else $error("empty window with a maximum other than the minimum");

  // A query keeps the request side closed in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == mp2d_pkg::REQ_QUERY) |=> !in_ready)
    else $error("request taken while a query is in progress");

endmodule

bind int8_max_pool_2d mp2d_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .req_type        (req.req_type),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .pooled_max      (rsp.pooled_max),
  .window_had_data (rsp.window_had_data)
);

@@ tb/tb_int8_max_pool_2d.sv @@
// Self-checking testbench of the int8 2-D max pooling block with random handshake stalls.
`timescale 1ns / 1ps
module tb_int8_max_pool_2d;

  localparam int STORE_DEPTH   = mp2d_pkg::MAX_ELEMS_DEF;
  localparam int FILTER_CAP    = mp2d_pkg::MAX_FILTER_DEF;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int PHASES        = 12;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SHOWN_ERRORS  = 10;
  localparam int IDLE_PERCENT  = 34;

  typedef enum {ROW_WRITE, ROW_QUERY, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        a;     // element address, or register index
    int        v;     // element value, or register data
    int        row;
    int        col;
    int        ch;
    bit        typed;
    int        want_max;
    bit        want_flag;
  } stim_row_t;

  typedef struct packed {
    logic signed [7:0] pooled_max;
    logic              window_had_data;
  } pool_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mp2d_in_if  req_if ();
  mp2d_out_if rsp_if ();
  mp2d_cfg_if cfg_if ();

  int8_max_pool_2d dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #6 clk = ~clk;

  // Shadow copy of the tensor and of the register file.
  logic signed [7:0]                tensor_img [STORE_DEPTH];
  bit                               written [STORE_DEPTH];
  logic [mp2d_pkg::DIM_W-1:0]       in_h, in_w;
  logic [mp2d_pkg::NCH_W-1:0]       n_ch;
  logic [mp2d_pkg::FCFG_W-1:0]      win_h, win_w, step_y, step_x;
  logic [mp2d_pkg::PAD_W-1:0]       pad_tl;

  pool_out_t pending_pools [$];
  stim_row_t stim_table [$];

  int  fails, shown, cycles;
  int  n_writes, n_queries, n_checked, n_settings;
  bit  calm;

  function automatic void set_reg(mp2d_pkg::cfg_reg_t idx,
                                  logic [mp2d_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      mp2d_pkg::REG_IN_HEIGHT:    in_h   = d;
      mp2d_pkg::REG_IN_WIDTH:     in_w   = d;
      mp2d_pkg::REG_CHANNELS:     n_ch   = d[mp2d_pkg::NCH_W-1:0];
      mp2d_pkg::REG_POOL_ROWS:    win_h  = d[mp2d_pkg::FCFG_W-1:0];
      mp2d_pkg::REG_POOL_COLS:    win_w  = d[mp2d_pkg::FCFG_W-1:0];
      mp2d_pkg::REG_STRIDE_Y:     step_y = d[mp2d_pkg::FCFG_W-1:0];
      mp2d_pkg::REG_STRIDE_X:     step_x = d[mp2d_pkg::FCFG_W-1:0];
      mp2d_pkg::REG_PAD_TOP_LEFT: pad_tl = d[mp2d_pkg::PAD_W-1:0];
      default: ;
    endcase
  endfunction

  // Flat store addresses of the real taps of one query window.
  function automatic void window_taps(input int row, input int col, input int ch,
                                      output int taps [$]);
    int     top, left, fh, fw, sy, sx, h, w, nc, r, c;
    longint a;
    top  = int'(pad_tl[5:3]);
    left = int'(pad_tl[2:0]);
    fh   = (int'(win_h) > FILTER_CAP) ? FILTER_CAP : int'(win_h);
    fw   = (int'(win_w) > FILTER_CAP) ? FILTER_CAP : int'(win_w);
    sy   = int'(step_y);
    sx   = int'(step_x);
    h    = int'(in_h);
    w    = int'(in_w);
    nc   = int'(n_ch);
    taps = {};
    if (ch >= nc) return;
    for (int fy = 0; fy < fh; fy++) begin
      r = row * sy + fy - top;
      if (r < 0 || r >= h) continue;
      for (int fx = 0; fx < fw; fx++) begin
        c = col * sx + fx - left;
        if (c < 0 || c >= w) continue;
        a = (longint'(r) * w + c) * nc + ch;
        if (a >= STORE_DEPTH) continue;
        taps.push_back(int'(a));
      end
    end
  endfunction

  function automatic pool_out_t pool_window(int row, int col, int ch);
    int                taps [$];
    logic signed [7:0] best;
    pool_out_t         res;
    window_taps(row, col, ch, taps);
    best = mp2d_pkg::MIN_VALUE;
    foreach (taps[i]) begin
      if (tensor_img[taps[i]] > best) best = tensor_img[taps[i]];
    end
    res.pooled_max      = best;
    res.window_had_data = (taps.size() != 0);
    return res;
  endfunction

  function automatic void add_row(row_kind_t kind, int a, int v, int row, int col, int ch,
                                  bit typed, int want_max, bit want_flag);
    stim_row_t s;
    s.kind = kind;
    s.a = a;
    s.v = v;
    s.row = row;
    s.col = col;
    s.ch = ch;
    s.typed = typed;
    s.want_max = want_max;
    s.want_flag = want_flag;
    stim_table.push_back(s);
  endfunction

  // Mostly small values, now and then one of three odd ones.
  function automatic int pick(int lo, int hi, int x, int y, int z);
    int r;
    r = $urandom_range(99);
    if (r < 5) return x;
    if (r < 10) return y;
    if (r < 15) return z;
    return $urandom_range(hi, lo);
  endfunction

  // Output coordinate that usually lands the window on the tensor.
  function automatic int coord_pick(int extent, int pad, int stride);
    int lim;
    if (stride == 0 || $urandom_range(99) >= 85) return $urandom_range(255);
    lim = (extent + pad) / stride;
    if (lim > 255) lim = 255;
    return $urandom_range(lim);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with valid still high.
  task automatic send_item(logic kind, int addr, int value, int row, int col, int ch,
                           bit typed, pool_out_t want);
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.elem_addr  <= mp2d_pkg::ADDR_W'(addr);
    req_if.elem_value <= 8'(value);
    req_if.out_row    <= mp2d_pkg::ROW_W'(row);
    req_if.out_col    <= mp2d_pkg::COL_W'(col);
    req_if.channel    <= mp2d_pkg::CH_W'(ch);
    do @(posedge clk); while (!req_if.ready);
    if (kind == mp2d_pkg::REQ_WRITE) begin
      tensor_img[addr % STORE_DEPTH] = 8'(value);
      written[addr % STORE_DEPTH] = 1'b1;
      n_writes++;
    end else begin
      pending_pools.push_back(typed ? want : pool_window(row, col, ch));
      n_queries++;
    end
    @(negedge clk);
  endtask

  task automatic send_write(int addr, int value);
    send_item(mp2d_pkg::REQ_WRITE, addr, value, $urandom_range(255), $urandom_range(255),
              $urandom_range(63), 1'b0, '0);
  endtask

  // Any tap not yet written gets a random value first, so no query reads an unset entry.
  task automatic send_query(int row, int col, int ch, bit typed, pool_out_t want);
    int taps [$];
    window_taps(row, col, ch, taps);
    foreach (taps[i]) begin
      if (!written[taps[i]]) send_write(taps[i], $urandom_range(255));
    end
    send_item(mp2d_pkg::REQ_QUERY, $urandom_range(STORE_DEPTH - 1), $urandom_range(255),
              row, col, ch, typed, want);
  endtask

  task automatic write_reg(mp2d_pkg::cfg_reg_t idx, int data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= mp2d_pkg::CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_if.ready);
    set_reg(idx, mp2d_pkg::CFG_DATA_W'(data));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every pooled result is back and the tap walk has surely finished.
  task automatic settle_block();
    req_if.valid <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item();
    int     k, addr, row, col, ch, nc;
    longint fp;
    k  = $urandom_range(99);
    fp = longint'(in_h) * longint'(in_w) * longint'(n_ch);
    if (fp > STORE_DEPTH) fp = STORE_DEPTH;
    if (k < 55) begin
      if (k < 45 && fp > 0) addr = $urandom_range(int'(fp) - 1);
      else addr = $urandom_range(STORE_DEPTH - 1);
      send_write(addr, $urandom_range(255));
    end else begin
      row = coord_pick(int'(in_h), int'(pad_tl[5:3]), int'(step_y));
      col = coord_pick(int'(in_w), int'(pad_tl[2:0]), int'(step_x));
      nc  = (int'(n_ch) > 64) ? 64 : int'(n_ch);
      if (nc > 0 && $urandom_range(99) < 85) ch = $urandom_range(nc - 1);
      else ch = $urandom_range(63);
      send_query(row, col, ch, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin : result_check
    pool_out_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_pools.size());
      $display("TB_ERROR");
      $finish;
    end else if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.pooled_max      = rsp_if.pooled_max;
      got.window_had_data = rsp_if.window_had_data;
      n_checked++;
      if (pending_pools.size() == 0) begin
        fails++;
        if (shown < SHOWN_ERRORS) begin
          shown++;
          $display("unexpected result transaction: max %0d flag %0b",
                   $signed(got.pooled_max), got.window_had_data);
        end
      end else begin
        want = pending_pools.pop_front();
        if (got !== want) begin
          fails++;
          if (shown < SHOWN_ERRORS) begin
            shown++;
            $display("result %0d: expected max %0d flag %0b, got max %0d flag %0b", n_checked,
                     $signed(want.pooled_max), want.window_had_data,
                     $signed(got.pooled_max), got.window_had_data);
          end
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t          srow;
    pool_out_t          want;
    int                 vals [8];
    int                 off, start;
    mp2d_pkg::cfg_reg_t idx;

    req_if.valid      = 1'b0;
    req_if.req_type   = mp2d_pkg::REQ_WRITE;
    req_if.elem_addr  = '0;
    req_if.elem_value = '0;
    req_if.out_row    = '0;
    req_if.out_col    = '0;
    req_if.channel    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = mp2d_pkg::REG_IN_HEIGHT;
    cfg_if.data       = '0;
    calm = 1'b0;

    in_h = mp2d_pkg::DIM_W'(1); in_w = mp2d_pkg::DIM_W'(1); n_ch = mp2d_pkg::NCH_W'(1);
    win_h = mp2d_pkg::FCFG_W'(2); win_w = mp2d_pkg::FCFG_W'(2);
    step_y = mp2d_pkg::FCFG_W'(2); step_x = mp2d_pkg::FCFG_W'(2); pad_tl = '0;

    // Reset settings: a 1x1x1 tensor under a 2x2 window with stride 2.
    add_row(ROW_QUERY, 0, 0, 0, 0, 1, 1, -128, 0);     // channel out of range
    add_row(ROW_QUERY, 0, 0, 1, 0, 0, 1, -128, 0);     // window below the tensor
    add_row(ROW_WRITE, 0, 127, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 0, 1, 127, 1);
    add_row(ROW_WRITE, 0, -128, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 0, 1, -128, 1);     // real tap equal to the floor
    add_row(ROW_WRITE, STORE_DEPTH - 1, -1, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 255, 255, 63, 1, -128, 0);
    add_row(ROW_REG, mp2d_pkg::REG_POOL_ROWS, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 0, 1, -128, 0);     // zero filter size
    // A tall column: rows 8 and 9 lie beyond a saturated window.
    add_row(ROW_REG, mp2d_pkg::REG_IN_HEIGHT, 10, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_POOL_ROWS, 15, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_POOL_COLS, 15, 0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE, 9, 127, 0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE, 8, 126, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_STRIDE_Y, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_STRIDE_X, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 200, 37, 0, 0, 0, 0);     // zero stride
    add_row(ROW_REG, mp2d_pkg::REG_PAD_TOP_LEFT, 63, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_CHANNELS, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 0, 1, -128, 0);     // no channels at all
    add_row(ROW_REG, mp2d_pkg::REG_CHANNELS, 127, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_IN_HEIGHT, 511, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_IN_WIDTH, 511, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 0, 63, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_PAD_TOP_LEFT, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REG, mp2d_pkg::REG_STRIDE_Y, 8, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 1, 0, 0, 1, -128, 0);     // every tap beyond the store

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_table[i]) begin
      srow = stim_table[i];
      want.pooled_max      = 8'(srow.want_max);
      want.window_had_data = srow.want_flag;
      case (srow.kind)
        ROW_REG: begin
          if (i == 0 || stim_table[i-1].kind != ROW_REG) settle_block();
          write_reg(mp2d_pkg::cfg_reg_t'(srow.a), srow.v);
        end
        ROW_WRITE: send_write(srow.a, srow.v);
        default: send_query(srow.row, srow.col, srow.ch, srow.typed, want);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      if (p == 0) begin
        vals = '{1, 1, 1, 1, 1, 1, 1, 0};
      end else if (p == 1) begin
        vals = '{256, 256, 64, 8, 8, 8, 8, 63};
      end else begin
        vals[mp2d_pkg::REG_IN_HEIGHT]    = pick(1, 12, 0, 256, 511);
        vals[mp2d_pkg::REG_IN_WIDTH]     = pick(1, 12, 0, 256, 511);
        vals[mp2d_pkg::REG_CHANNELS]     = pick(1, 6, 0, 64, 127);
        vals[mp2d_pkg::REG_POOL_ROWS]    = pick(1, 8, 0, 15, 11);
        vals[mp2d_pkg::REG_POOL_COLS]    = pick(1, 8, 0, 15, 11);
        vals[mp2d_pkg::REG_STRIDE_Y]     = pick(1, 4, 0, 8, 15);
        vals[mp2d_pkg::REG_STRIDE_X]     = pick(1, 4, 0, 8, 15);
        vals[mp2d_pkg::REG_PAD_TOP_LEFT] = $urandom_range(63);
      end
      off = $urandom_range(7);
      for (int k = 0; k < 8; k++) begin
        idx = mp2d_pkg::cfg_reg_t'((k + off) % 8);
        write_reg(idx, vals[idx]);
      end
      n_settings++;
      // One phase in the middle runs with neither side stalling.
      calm = (p == PHASES / 2);
      start = n_writes + n_queries;
      while (n_writes + n_queries - start < RANDOM_ITEMS / PHASES) random_item();
    end
    calm = 1'b0;
    settle_block();

    $display("Checked %0d pooled results from %0d queries and %0d element writes.",
             n_checked, n_queries, n_writes);
    $display("Random traffic ran under %0d register settings; %0d mismatches seen.",
             n_settings, fails);
    if (fails == 0 && pending_pools.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
